// ===== sv/icmprc_pkg.sv =====
// Shared types and constants of the ICMP reply classifier.
package icmprc_pkg;

  // Configuration port
  localparam int unsigned ADDR_W = 2;
  localparam int unsigned DATA_W = 32;
  localparam logic [ADDR_W-1:0] REG_EXP_SEQ_ADDR = 2'd0;
  localparam logic [15:0] EXP_SEQ_RESET = 16'd1;

  // ICMP message types
  localparam logic [7:0] ICMP_ECHO_REPLY    = 8'd0;
  localparam logic [7:0] ICMP_TIME_EXCEEDED = 8'd11;

  // Offsets inside an ICMP header
  localparam int unsigned OFS_ID_LO  = 4;
  localparam int unsigned OFS_ID_HI  = 5;
  localparam int unsigned OFS_SEQ_LO = 6;
  localparam int unsigned OFS_SEQ_HI = 7;
  // Quoted inner IP header starts this far after the outer ICMP header
  localparam int unsigned OFS_INNER_IP = 8;

  typedef struct packed {
    logic [7:0]  message_type;
    logic [15:0] identifier;
    logic [15:0] sequence_res;
    logic        matches_res;
    logic        truncated;
  } res_t;

endpackage

// ===== sv/icmprc_cfg.sv =====
// APB register file holding the expected sequence value.
module icmprc_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [icmprc_pkg::ADDR_W-1:0]     paddr,
  input  logic [icmprc_pkg::DATA_W-1:0]     pwdata,
  output logic [icmprc_pkg::DATA_W-1:0]     prdata,
  output logic                              pready,
  output logic [15:0]                       exp_seq_o
);

  logic [15:0] exp_seq_q;
  logic        wr_en;

  assign wr_en  = psel & penable & pwrite & (paddr == icmprc_pkg::REG_EXP_SEQ_ADDR);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_seq_q <= icmprc_pkg::EXP_SEQ_RESET;
    end else if (wr_en) begin
      exp_seq_q <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == icmprc_pkg::REG_EXP_SEQ_ADDR) begin
      prdata = {{(icmprc_pkg::DATA_W-16){1'b0}}, exp_seq_q};
    end
  end

  assign exp_seq_o = exp_seq_q;

endmodule

// ===== sv/icmprc_parse.sv =====
// Per-packet parse state and the result formed on the last byte.
module icmprc_parse #(
  parameter int unsigned MAX_PACKET_BYTES = 65535
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               beat_i,
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  input  logic [15:0]        exp_seq_i,
  output icmprc_pkg::res_t   res_o
);

  localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned CW    = (POS_W > 8) ? POS_W : 8;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [5:0]       hdr_q, hdr_d;
  logic [7:0]       inner_q, inner_d;
  logic [7:0]       type_q, type_d;
  logic [15:0]      id_q, id_d;
  logic [15:0]      seq_q, seq_d;
  logic             ftype_q, ftype_d;
  logic             finner_q, finner_d;
  logic             fdone_q, fdone_d;

  logic             active;
  logic [CW-1:0]    pos_ext, hdr_ext, inner_ext, rel;
  logic             take_en;
  logic             have_type, needs, trunc;

  always_comb begin
    hdr_d    = hdr_q;
    inner_d  = inner_q;
    type_d   = type_q;
    id_d     = id_q;
    seq_d    = seq_q;
    ftype_d  = ftype_q;
    finner_d = finner_q;
    fdone_d  = fdone_q;
    pos_d    = pos_q;
    take_en  = 1'b0;
    rel      = '0;

    active  = (pos_q < POS_W'(MAX_PACKET_BYTES));
    pos_ext = CW'(pos_q);

    if (active && (pos_q == '0)) begin
      hdr_d = {byte_i[3:0], 2'b00};
    end
    hdr_ext   = CW'(hdr_d);
    inner_ext = CW'(inner_q);

    if (active) begin
      if ((pos_ext == hdr_ext) && !ftype_q) begin
        type_d  = byte_i;
        ftype_d = 1'b1;
      end
      // Type can only be captured at the header offset, so the old flag is enough here
      if (ftype_q && !fdone_q && (pos_ext > hdr_ext)) begin
        if (type_q == icmprc_pkg::ICMP_ECHO_REPLY) begin
          take_en = 1'b1;
          rel     = pos_ext - hdr_ext;
        end else if (type_q == icmprc_pkg::ICMP_TIME_EXCEEDED) begin
          if (pos_ext == hdr_ext + CW'(icmprc_pkg::OFS_INNER_IP)) begin
            inner_d  = 8'(hdr_d) + 8'(icmprc_pkg::OFS_INNER_IP) + {2'b00, byte_i[3:0], 2'b00};
            finner_d = 1'b1;
          end
          inner_ext = CW'(inner_d);
          if (finner_d && (pos_ext >= inner_ext)) begin
            take_en = 1'b1;
            rel     = pos_ext - inner_ext;
          end
        end
      end
      if (take_en) begin
        if (rel == CW'(icmprc_pkg::OFS_ID_LO)) begin
          id_d = {id_q[15:8], byte_i};
        end else if (rel == CW'(icmprc_pkg::OFS_ID_HI)) begin
          id_d = {byte_i, id_q[7:0]};
        end else if (rel == CW'(icmprc_pkg::OFS_SEQ_LO)) begin
          seq_d = {seq_q[15:8], byte_i};
        end else if (rel == CW'(icmprc_pkg::OFS_SEQ_HI)) begin
          seq_d   = {byte_i, seq_q[7:0]};
          fdone_d = 1'b1;
        end
      end
      pos_d = pos_q + POS_W'(1);
    end

    have_type = ftype_d;
    needs     = have_type && ((type_d == icmprc_pkg::ICMP_ECHO_REPLY) ||
                              (type_d == icmprc_pkg::ICMP_TIME_EXCEEDED));
    trunc     = !have_type || (needs && !fdone_d);

    res_o.message_type = have_type ? type_d : 8'd0;
    res_o.identifier   = trunc ? 16'd0 : id_d;
    res_o.sequence_res = trunc ? 16'd0 : seq_d;
    res_o.matches_res  = !trunc && (seq_d == exp_seq_i);
    res_o.truncated    = trunc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      hdr_q    <= '0;
      inner_q  <= '0;
      type_q   <= '0;
      id_q     <= '0;
      seq_q    <= '0;
      ftype_q  <= 1'b0;
      finner_q <= 1'b0;
      fdone_q  <= 1'b0;
    end else if (beat_i) begin
      if (last_i) begin
        // Clear for the next packet
        pos_q    <= '0;
        hdr_q    <= '0;
        inner_q  <= '0;
        type_q   <= '0;
        id_q     <= '0;
        seq_q    <= '0;
        ftype_q  <= 1'b0;
        finner_q <= 1'b0;
        fdone_q  <= 1'b0;
      end else begin
        pos_q    <= pos_d;
        hdr_q    <= hdr_d;
        inner_q  <= inner_d;
        type_q   <= type_d;
        id_q     <= id_d;
        seq_q    <= seq_d;
        ftype_q  <= ftype_d;
        finner_q <= finner_d;
        fdone_q  <= fdone_d;
      end
    end
  end

endmodule

// ===== sv/icmp_reply_classifier.sv =====
// ICMP reply classifier: byte stream in, one result per packet out.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one byte of a received
//   IPv4 packet per beat in wire order; last_byte_i marks the final byte.
//   Output channel (out_valid_o/out_ready_i) carries one result per packet:
//   outer ICMP type, identifier, sequence, match flag and truncation flag.
//   expected_sequence sits at APB address 0; write it only while idle.
//   A last byte sits in the input register until the result register is
//   free, then the result register takes the parse output.
//   Throughput: one byte per cycle unless a last byte is held, set by the
//   single-pass parse between the input register and the result register.
//   Reset clears the parse state and the valid flags of both registers;
//   expected_sequence returns to 1.
//   A stalled receiver holds the result; bytes that produce no result keep
//   flowing, and a last byte waits in the input register until the result
//   register frees up.
module icmp_reply_classifier #(
  parameter int unsigned MAX_PACKET_BYTES = 65535
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    packet_byte_i,
  input  logic                          last_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    message_type_o,
  output logic [15:0]                   identifier_o,
  output logic [15:0]                   sequence_res_o,
  output logic                          matches_res_o,
  output logic                          truncated_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [icmprc_pkg::ADDR_W-1:0] paddr,
  input  logic [icmprc_pkg::DATA_W-1:0] pwdata,
  output logic [icmprc_pkg::DATA_W-1:0] prdata,
  output logic                          pready
);

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              in_last_q;
  logic              out_valid_q;
  icmprc_pkg::res_t  res_q, res_d;
  logic              out_free;
  logic              adv;
  logic [15:0]       exp_seq;

  icmprc_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .exp_seq_o (exp_seq)
  );

  icmprc_parse #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .beat_i    (adv),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .exp_seq_i (exp_seq),
    .res_o     (res_d)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  // Advance the held byte unless it is a last byte facing a full result register
  assign adv        = in_valid_q && (!in_last_q || out_free);
  assign in_ready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= packet_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= adv && in_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_last_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign message_type_o = res_q.message_type;
  assign identifier_o   = res_q.identifier;
  assign sequence_res_o = res_q.sequence_res;
  assign matches_res_o  = res_q.matches_res;
  assign truncated_o    = res_q.truncated;

`ifndef ASSERT_OFF
  a_ready_low_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && in_last_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked last byte");

  a_result_from_last_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(adv && in_last_q))
    else $error("result raised without a last byte");

  a_trunc_clears_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.truncated) |->
      (res_q.identifier == 16'd0 && res_q.sequence_res == 16'd0 && !res_q.matches_res))
    else $error("truncated result carries captured fields");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !(adv && in_last_q))
    else $error("pending result overwritten");
`endif

endmodule

// ===== bench/icmp_reply_classifier_tb.sv =====
// Self-checking bench for the ICMP reply classifier: random IPv4 packets, APB setup, scoreboard.
`timescale 1ns / 100ps

module icmp_reply_classifier_tb;

  localparam int unsigned MAX_BYTES = 65535;
  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned BEATS_PER_PHASE = 330;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef enum int {PK_ECHO, PK_TIME_EXC, PK_OTHER, PK_NOISE} pkt_kind_e;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] packet_byte = 8'h00;
  logic is_last = 1'b0;
  logic out_ready = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [icmprc_pkg::ADDR_W-1:0] paddr = '0;
  logic [icmprc_pkg::DATA_W-1:0] pwdata = '0;

  logic in_ready_o;
  logic out_valid_o;
  logic [7:0] message_type_o;
  logic [15:0] identifier_o;
  logic [15:0] sequence_res_o;
  logic matches_res_o;
  logic truncated_o;
  logic [icmprc_pkg::DATA_W-1:0] prdata;
  logic pready;

  icmp_reply_classifier #(
    .MAX_PACKET_BYTES(MAX_BYTES)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .packet_byte_i (packet_byte),
    .last_byte_i   (is_last),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .message_type_o(message_type_o),
    .identifier_o  (identifier_o),
    .sequence_res_o(sequence_res_o),
    .matches_res_o (matches_res_o),
    .truncated_o   (truncated_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk_i = ~clk_i;

  beat_t pending_beats[$];
  icmprc_pkg::res_t replies_due[$];

  // Parser shadow state
  logic [15:0] exp_seq_cfg = icmprc_pkg::EXP_SEQ_RESET;
  logic [15:0] pos_cnt = '0;
  logic [5:0] hdr_bytes = '0;
  logic [15:0] inner_at = '0;
  logic [7:0] type_val = '0;
  logic [15:0] id_val = '0;
  logic [15:0] seq_val = '0;
  logic seen_type = 1'b0;
  logic seen_inner = 1'b0;
  logic seen_seq = 1'b0;

  int unsigned mismatches = 0;
  int unsigned replies_checked = 0;
  int unsigned packets_sent = 0;
  int unsigned n_echo = 0;
  int unsigned n_time_exc = 0;
  int unsigned n_trunc = 0;
  int unsigned n_match = 0;
  int unsigned cycle_cnt = 0;

  bit in_busy = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_timer = 0;
  int unsigned stall_mode = 0;
  logic [31:0] stall_pat = '0;
  logic ready_next = 1'b0;
  beat_t cur_beat;

  task automatic grab_id_seq(input int unsigned rel, input logic [7:0] b);
    if (rel == icmprc_pkg::OFS_ID_LO) id_val[7:0] = b;
    else if (rel == icmprc_pkg::OFS_ID_HI) id_val[15:8] = b;
    else if (rel == icmprc_pkg::OFS_SEQ_LO) seq_val[7:0] = b;
    else if (rel == icmprc_pkg::OFS_SEQ_HI) begin
      seq_val[15:8] = b;
      seen_seq = 1'b1;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic fin);
    icmprc_pkg::res_t r;
    logic wants_seq;
    logic short_pkt;
    if (pos_cnt < MAX_BYTES) begin
      if (pos_cnt == 0) hdr_bytes = {b[3:0], 2'b00};
      if (pos_cnt == 16'(hdr_bytes) && !seen_type) begin
        type_val = b;
        seen_type = 1'b1;
      end
      if (seen_type && !seen_seq && pos_cnt > 16'(hdr_bytes)) begin
        if (type_val == icmprc_pkg::ICMP_ECHO_REPLY) begin
          grab_id_seq(32'(pos_cnt - 16'(hdr_bytes)), b);
        end else if (type_val == icmprc_pkg::ICMP_TIME_EXCEEDED) begin
          if (32'(pos_cnt) == 32'(hdr_bytes) + icmprc_pkg::OFS_INNER_IP) begin
            inner_at = 16'(32'(hdr_bytes) + icmprc_pkg::OFS_INNER_IP + 32'({b[3:0], 2'b00}));
            seen_inner = 1'b1;
          end
          if (seen_inner && pos_cnt >= inner_at) grab_id_seq(32'(pos_cnt - inner_at), b);
        end
      end
      pos_cnt = pos_cnt + 16'd1;
    end
    if (fin) begin
      wants_seq = seen_type &&
                  (type_val == icmprc_pkg::ICMP_ECHO_REPLY ||
                   type_val == icmprc_pkg::ICMP_TIME_EXCEEDED);
      short_pkt = !seen_type || (wants_seq && !seen_seq);
      r.message_type = seen_type ? type_val : 8'd0;
      r.identifier = short_pkt ? 16'd0 : id_val;
      r.sequence_res = short_pkt ? 16'd0 : seq_val;
      r.matches_res = !short_pkt && (r.sequence_res == exp_seq_cfg);
      r.truncated = short_pkt;
      replies_due.push_back(r);
      pos_cnt = '0;
      hdr_bytes = '0;
      inner_at = '0;
      type_val = '0;
      id_val = '0;
      seq_val = '0;
      seen_type = 1'b0;
      seen_inner = 1'b0;
      seen_seq = 1'b0;
    end
  endtask

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at reply %0d: expected 0x%0h, got 0x%0h",
               what, replies_checked, want, got);
  endtask

  // Build one packet with random filler and queue its beats
  task automatic add_packet(input pkt_kind_e kind, input logic [3:0] ihl,
                            input logic [3:0] inner_ihl, input logic [15:0] ident,
                            input logic [15:0] seqv, input int pad,
                            output int unsigned len);
    logic [7:0] pkt[];
    logic [31:0] idseq;
    logic [7:0] kind_type;
    int unsigned hdr;
    int unsigned base;
    int unsigned need;
    int unsigned k;
    int span;
    beat_t bt;
    hdr = 4 * ihl;
    base = (kind == PK_TIME_EXC) ? hdr + icmprc_pkg::OFS_INNER_IP + 4 * inner_ihl : hdr;
    case (kind)
      PK_ECHO, PK_TIME_EXC: need = base + icmprc_pkg::OFS_SEQ_HI + 1;
      PK_OTHER: need = hdr + 1;
      default: need = $urandom_range(1, 80);
    endcase
    span = int'(need) + pad;
    len = (span < 1) ? 1 : span;
    pkt = new[len];
    for (k = 0; k < len; k++) pkt[k] = 8'($urandom);
    idseq = {seqv, ident};
    if (kind != PK_NOISE) begin
      pkt[0] = {4'h4, ihl};
      case (kind)
        PK_ECHO: kind_type = icmprc_pkg::ICMP_ECHO_REPLY;
        PK_TIME_EXC: kind_type = icmprc_pkg::ICMP_TIME_EXCEEDED;
        default: begin
          kind_type = 8'($urandom);
          if (kind_type == icmprc_pkg::ICMP_ECHO_REPLY ||
              kind_type == icmprc_pkg::ICMP_TIME_EXCEEDED)
            kind_type = kind_type ^ 8'h80;
        end
      endcase
      // with IHL 0 the first byte doubles as the type byte
      if (hdr == 0) begin
        if (kind == PK_ECHO) pkt[0] = icmprc_pkg::ICMP_ECHO_REPLY;
      end else if (hdr < len) begin
        pkt[hdr] = kind_type;
      end
      if (kind == PK_TIME_EXC && hdr + icmprc_pkg::OFS_INNER_IP < len)
        pkt[hdr + icmprc_pkg::OFS_INNER_IP] = {4'h4, inner_ihl};
      if (kind == PK_ECHO || kind == PK_TIME_EXC)
        for (k = 0; k < 4; k++)
          if (base + icmprc_pkg::OFS_ID_LO + k < len)
            pkt[base + icmprc_pkg::OFS_ID_LO + k] = idseq[8*k +: 8];
    end
    for (k = 0; k < len; k++) begin
      bt.data = pkt[k];
      bt.is_last = (k == len - 1);
      pending_beats.push_back(bt);
    end
    packets_sent++;
  endtask

  task automatic random_packets(input int unsigned beats);
    int unsigned sent;
    int unsigned n;
    int unsigned pick;
    logic [3:0] ihl;
    logic [3:0] inner_ihl;
    logic [15:0] ident;
    logic [15:0] seqv;
    int pad;
    pkt_kind_e kind;
    sent = 0;
    while (sent < beats) begin
      pick = $urandom_range(0, 99);
      if (pick < 38) kind = PK_ECHO;
      else if (pick < 76) kind = PK_TIME_EXC;
      else if (pick < 88) kind = PK_OTHER;
      else kind = PK_NOISE;
      ihl = ($urandom_range(0, 9) < 7) ? 4'd5 : 4'($urandom_range(0, 15));
      inner_ihl = ($urandom_range(0, 9) < 6) ? 4'd5 : 4'($urandom_range(0, 15));
      ident = 16'($urandom);
      case ($urandom_range(0, 5))
        0, 1: seqv = exp_seq_cfg;
        2: seqv = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        default: seqv = 16'($urandom);
      endcase
      pad = $urandom_range(0, 24);
      // cut some packets short
      if ($urandom_range(0, 6) == 0) pad = -int'($urandom_range(1, 140));
      add_packet(kind, ihl, inner_ihl, ident, seqv, pad, n);
      sent += n;
    end
  endtask

  task automatic apb_access(input bit wr, input logic [15:0] val,
                            output logic [icmprc_pkg::DATA_W-1:0] rd);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= icmprc_pkg::REG_EXP_SEQ_ADDR;
    pwdata <= {{(icmprc_pkg::DATA_W-16){1'b0}}, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    if (wr) exp_seq_cfg = val;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_expected_sequence(input logic [15:0] val);
    logic [icmprc_pkg::DATA_W-1:0] rd;
    apb_access(1'b1, val, rd);
    apb_access(1'b0, 16'd0, rd);
    if (rd[15:0] !== val)
      flag_mismatch("expected_sequence readback", 32'(val), 32'(rd[15:0]));
  endtask

  task automatic drain;
    while (pending_beats.size() != 0 || in_busy || replies_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Sender: bursts of beats separated by random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_busy) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        cur_beat = pending_beats.pop_front();
        in_valid <= 1'b1;
        packet_byte <= cur_beat.data;
        is_last <= cur_beat.is_last;
        in_busy = 1'b1;
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
                                                    : $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall mode changes every so often
  always @(negedge clk_i) begin
    if (stall_timer == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_pat = $urandom;
      stall_timer = $urandom_range(20, 150);
    end else begin
      stall_timer--;
    end
    case (stall_mode)
      0: ready_next = 1'b1;
      1: ready_next = ($urandom_range(0, 3) != 0);
      2: begin
        ready_next = stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[31:1]};
      end
      default: ready_next = 1'($urandom_range(0, 1));
    endcase
    out_ready <= ready_next;
  end

  // Accept input beats into the predictor and check reply beats
  always @(posedge clk_i) begin
    icmprc_pkg::res_t want;
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        in_busy = 1'b0;
        parse_byte(packet_byte, is_last);
      end
      if (out_valid_o && out_ready) begin
        if (replies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("reply with nothing expected: type 0x%0h id 0x%0h seq 0x%0h",
                     message_type_o, identifier_o, sequence_res_o);
        end else begin
          want = replies_due.pop_front();
          if (message_type_o !== want.message_type)
            flag_mismatch("message_type", 32'(want.message_type), 32'(message_type_o));
          if (identifier_o !== want.identifier)
            flag_mismatch("identifier", 32'(want.identifier), 32'(identifier_o));
          if (sequence_res_o !== want.sequence_res)
            flag_mismatch("sequence_res", 32'(want.sequence_res), 32'(sequence_res_o));
          if (matches_res_o !== want.matches_res)
            flag_mismatch("matches_res", 32'(want.matches_res), 32'(matches_res_o));
          if (truncated_o !== want.truncated)
            flag_mismatch("truncated", 32'(want.truncated), 32'(truncated_o));
          if (want.message_type == icmprc_pkg::ICMP_ECHO_REPLY) n_echo++;
          if (want.message_type == icmprc_pkg::ICMP_TIME_EXCEEDED) n_time_exc++;
          if (want.truncated) n_trunc++;
          if (want.matches_res) n_match++;
        end
        replies_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies still due", cycle_cnt,
               replies_due.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    int unsigned phase;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (phase = 0; phase < 5; phase++) begin
      if (phase > 0) begin
        drain;
        case (phase)
          1: set_expected_sequence(16'h0000);
          2: set_expected_sequence(16'hFFFF);
          3: set_expected_sequence(16'($urandom));
          default: set_expected_sequence(16'($urandom_range(1, 30)));
        endcase
      end
      if (phase == 0) begin
        // one-byte packet: type never reached
        add_packet(PK_OTHER, 4'd5, 4'd5, 16'h0000, 16'h0000, -100, n);
        // IHL 0 echo reply, all-ones id and sequence
        add_packet(PK_ECHO, 4'd0, 4'd0, 16'hFFFF, 16'hFFFF, 0, n);
        // IHL 0 with some other type: first byte is the type
        add_packet(PK_OTHER, 4'd0, 4'd0, 16'h0000, 16'h0000, 0, n);
        // time exceeded with inner IHL 0, sequence at the reset match value
        add_packet(PK_TIME_EXC, 4'd1, 4'd0, 16'h0000, icmprc_pkg::EXP_SEQ_RESET, 0, n);
      end
      random_packets(BEATS_PER_PHASE);
    end

    drain;
    if (replies_due.size() != 0) begin
      mismatches += replies_due.size();
      $display("%0d replies never arrived", replies_due.size());
    end
    $display("Covered %0d packets in 5 expected_sequence settings: %0d replies checked,",
             packets_sent, replies_checked);
    $display("  %0d echo, %0d time-exceeded, %0d truncated, %0d sequence matches",
             n_echo, n_time_exc, n_trunc, n_match);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
